FILE: rtl/core/ihq_pkg.sv
// ----------------------------------------------------------------------------
// ihq_pkg
// Types and constants for the indexed max-heap update queue.
// ----------------------------------------------------------------------------
package ihq_pkg;

    localparam int VERTEX_W = 7;
    localparam int PRIO_W   = 32;

    localparam logic signed [PRIO_W-1:0] UNSEEN_MARK = 32'sh8000_0001;

    localparam logic [1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [1:0] FUNC_UPDATE  = 2'd1;
    localparam logic [1:0] FUNC_EXTRACT = 2'd2;
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    typedef struct packed {
        logic [1:0]                func;
        logic [VERTEX_W-1:0]       vertex_id;
        logic signed [PRIO_W-1:0]  priority_req;
    } in_t;

    typedef struct packed {
        logic [VERTEX_W-1:0]       vertex_out;
        logic signed [PRIO_W-1:0]  priority_out;
        logic                      changed;
        logic                      queue_empty;
        logic                      error;
    } out_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_UP_TEST,
        S_UP_PV,
        S_UP_CMP,
        S_RAISE_CHK,
        S_RB_TEST,
        S_SD_V,
        S_SD_PV,
        S_SD_TEST,
        S_SD_LH,
        S_SD_LP,
        S_SD_RH,
        S_SD_RP,
        S_SD_CMP,
        S_EX_V,
        S_EX_P,
        S_EX_L,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CLEAR,
        OP_SET_ERR,
        OP_INS,
        OP_WR_KV,
        OP_RD_PARENT,
        OP_RD_PRIO_HD,
        OP_UP_MOVE,
        OP_RD_PRIO_VID,
        OP_RAISE,
        OP_SD_START_R,
        OP_SD_LDV,
        OP_SD_LDPV,
        OP_RD_LEFT,
        OP_LD_PC,
        OP_LD_PC_RD_R,
        OP_RD_PRIO_HD1,
        OP_TAKE_RIGHT,
        OP_SD_MOVE,
        OP_RD_ROOT,
        OP_EX_LDV,
        OP_EX_LDP,
        OP_EX_MOVE,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        logic [1:0] func;
        logic       bad_upd;
        logic       unseen;
        logic       full;
        logic       empty;
        logic       count_one;
        logic       k_is_root;
        logic       k_is_leaf;
        logic       has_right;
        logic       up_le;
        logic       raise_ok;
        logic       right_gt;
        logic       stop;
        logic       r_zero;
        logic       out_busy;
    } dp_status_t;

endpackage

FILE: rtl/core/ihq_ram.sv
// ----------------------------------------------------------------------------
// ihq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ihq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/ihq_ctrl.sv
// ----------------------------------------------------------------------------
// ihq_ctrl
// Sequencer for clear, insert/sift-up, raise/rebuild and extract/sift-down.
// ----------------------------------------------------------------------------
module ihq_ctrl
    import ihq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t st,
    output dp_op_t     op
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE) && !st.out_busy;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op         = OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                case (st.func)
                    FUNC_CLEAR: op = OP_CLEAR;
                    FUNC_UPDATE:
                    begin
                        if (!st.bad_upd)
                        begin
                            if (!st.unseen)
                            begin
                                op         = OP_RD_PRIO_VID;
                                state_next = S_RAISE_CHK;
                            end
                            else if (st.full)
                            begin
                                op = OP_SET_ERR;
                            end
                            else
                            begin
                                op         = OP_INS;
                                state_next = S_UP_TEST;
                            end
                        end
                    end
                    FUNC_EXTRACT:
                    begin
                        if (st.empty)
                        begin
                            op = OP_SET_ERR;
                        end
                        else
                        begin
                            op         = OP_RD_ROOT;
                            state_next = S_EX_V;
                        end
                    end
                    default: op = OP_NONE;
                endcase
            end
            S_UP_TEST:
            begin
                if (st.k_is_root)
                begin
                    op         = OP_WR_KV;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = OP_RD_PARENT;
                    state_next = S_UP_PV;
                end
            end
            S_UP_PV:
            begin
                op         = OP_RD_PRIO_HD;
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (st.up_le)
                begin
                    op         = OP_UP_MOVE;
                    state_next = S_UP_TEST;
                end
                else
                begin
                    op         = OP_WR_KV;
                    state_next = S_DONE;
                end
            end
            S_RAISE_CHK:
            begin
                if (st.raise_ok)
                begin
                    op         = OP_RAISE;
                    state_next = S_RB_TEST;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RB_TEST:
            begin
                if (st.r_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    op         = OP_SD_START_R;
                    state_next = S_SD_V;
                end
            end
            S_SD_V:
            begin
                op         = OP_SD_LDV;
                state_next = S_SD_PV;
            end
            S_SD_PV:
            begin
                op         = OP_SD_LDPV;
                state_next = S_SD_TEST;
            end
            S_SD_TEST:
            begin
                if (st.k_is_leaf)
                begin
                    op         = OP_WR_KV;
                    state_next = (st.func == FUNC_UPDATE) ? S_RB_TEST : S_DONE;
                end
                else
                begin
                    op         = OP_RD_LEFT;
                    state_next = S_SD_LH;
                end
            end
            S_SD_LH:
            begin
                op         = OP_RD_PRIO_HD;
                state_next = S_SD_LP;
            end
            S_SD_LP:
            begin
                if (st.has_right)
                begin
                    op         = OP_LD_PC_RD_R;
                    state_next = S_SD_RH;
                end
                else
                begin
                    op         = OP_LD_PC;
                    state_next = S_SD_CMP;
                end
            end
            S_SD_RH:
            begin
                op         = OP_RD_PRIO_HD1;
                state_next = S_SD_RP;
            end
            S_SD_RP:
            begin
                if (st.right_gt)
                begin
                    op = OP_TAKE_RIGHT;
                end
                state_next = S_SD_CMP;
            end
            S_SD_CMP:
            begin
                if (st.stop)
                begin
                    op         = OP_WR_KV;
                    state_next = (st.func == FUNC_UPDATE) ? S_RB_TEST : S_DONE;
                end
                else
                begin
                    op         = OP_SD_MOVE;
                    state_next = S_SD_TEST;
                end
            end
            S_EX_V:
            begin
                op         = OP_EX_LDV;
                state_next = S_EX_P;
            end
            S_EX_P:
            begin
                op         = OP_EX_LDP;
                state_next = S_EX_L;
            end
            S_EX_L:
            begin
                op         = OP_EX_MOVE;
                state_next = st.count_one ? S_DONE : S_SD_PV;
            end
            S_DONE:
            begin
                op         = OP_FINISH;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_ACCEPT) |=> (state_reg == S_DISPATCH))
        else $error("accept did not enter dispatch");
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_FINISH) |=> (state_reg == S_IDLE) && !in_ready)
        else $error("finish did not block next request");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE) && !st.out_busy)
        else $error("ready outside idle");
`endif

endmodule

FILE: rtl/core/ihq_datapath.sv
// ----------------------------------------------------------------------------
// ihq_datapath
// Heap and priority stores, walk registers, seen bits and result register.
// ----------------------------------------------------------------------------
module ihq_datapath
    import ihq_pkg::*;
#(
    parameter int MAX_VERTICES = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_op_t     op,
    output dp_status_t st,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_data
);

    localparam int PD  = (MAX_VERTICES < (1 << VERTEX_W)) ? MAX_VERTICES : (1 << VERTEX_W);
    localparam int PAW = $clog2(PD);
    localparam int HAW = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] FULL = CW'(MAX_VERTICES);

    logic [1:0]               func_reg;
    logic [VERTEX_W-1:0]      vid_reg;
    logic signed [PRIO_W-1:0] req_reg;
    logic [CW-1:0]            count_reg, k_reg, c_reg, r_reg;
    logic [VERTEX_W-1:0]      v_reg, hc_reg, hc1_reg;
    logic signed [PRIO_W-1:0] pv_reg, pc_reg;
    logic [PD-1:0]            valid_reg;
    logic                     out_valid_reg;
    out_t                     out_reg;

    logic                     h_we, h_re, p_we, p_re;
    logic [CW-1:0]            h_wpos, h_rpos;
    logic [VERTEX_W-1:0]      h_wdata, h_rdata;
    logic [PAW-1:0]           p_waddr, p_raddr;
    logic [PRIO_W-1:0]        p_rdata;
    logic signed [PRIO_W-1:0] prio_rd;
    logic [CW-1:0]            h_waddr_full, h_raddr_full;

    assign prio_rd      = $signed(p_rdata);
    assign h_waddr_full = h_wpos - ONE;
    assign h_raddr_full = h_rpos - ONE;

    ihq_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_VERTICES)) u_heap (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr_full[HAW-1:0]),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr_full[HAW-1:0]),
        .rdata (h_rdata)
    );

    ihq_ram #(.WIDTH(PRIO_W), .DEPTH(PD)) u_prio (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (req_reg),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    always_comb
    begin
        h_we    = 1'b0;
        h_wpos  = k_reg;
        h_wdata = v_reg;
        h_re    = 1'b0;
        h_rpos  = ONE;
        p_we    = 1'b0;
        p_waddr = vid_reg[PAW-1:0];
        p_re    = 1'b0;
        p_raddr = h_rdata[PAW-1:0];
        case (op)
            OP_INS, OP_RAISE: p_we = 1'b1;
            OP_WR_KV:         h_we = 1'b1;
            OP_RD_PARENT:
            begin
                h_re   = 1'b1;
                h_rpos = k_reg >> 1;
            end
            OP_RD_PRIO_HD, OP_RD_PRIO_HD1, OP_SD_LDV, OP_EX_LDV: p_re = 1'b1;
            OP_UP_MOVE, OP_SD_MOVE:
            begin
                h_we    = 1'b1;
                h_wdata = hc_reg;
            end
            OP_RD_PRIO_VID:
            begin
                p_re    = 1'b1;
                p_raddr = vid_reg[PAW-1:0];
            end
            OP_SD_START_R:
            begin
                h_re   = 1'b1;
                h_rpos = r_reg;
            end
            OP_RD_LEFT:
            begin
                h_re   = 1'b1;
                h_rpos = k_reg << 1;
            end
            OP_LD_PC_RD_R:
            begin
                h_re   = 1'b1;
                h_rpos = c_reg + ONE;
            end
            OP_RD_ROOT:       h_re = 1'b1;
            OP_EX_LDP:
            begin
                h_re   = 1'b1;
                h_rpos = count_reg;
            end
            OP_EX_MOVE:
            begin
                h_we    = 1'b1;
                h_wpos  = ONE;
                h_wdata = h_rdata;
                p_re    = 1'b1;
            end
            default: h_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                OP_CLEAR:
                begin
                    count_reg <= '0;
                    valid_reg <= '0;
                end
                OP_INS:
                begin
                    count_reg                    <= count_reg + ONE;
                    valid_reg[vid_reg[PAW-1:0]] <= 1'b1;
                end
                OP_EX_MOVE: count_reg     <= count_reg - ONE;
                OP_FINISH:  out_valid_reg <= 1'b1;
                default:    count_reg     <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_ACCEPT:
            begin
                func_reg             <= in_data.func;
                vid_reg              <= in_data.vertex_id;
                req_reg              <= in_data.priority_req;
                out_reg.vertex_out   <= '0;
                out_reg.priority_out <= '0;
                out_reg.changed      <= 1'b0;
                out_reg.error        <= 1'b0;
            end
            OP_SET_ERR: out_reg.error <= 1'b1;
            OP_INS:
            begin
                k_reg           <= count_reg + ONE;
                v_reg           <= vid_reg;
                pv_reg          <= req_reg;
                out_reg.changed <= 1'b1;
            end
            OP_RD_PRIO_HD: hc_reg <= h_rdata;
            OP_UP_MOVE:    k_reg  <= k_reg >> 1;
            OP_RAISE:
            begin
                r_reg           <= count_reg >> 1;
                out_reg.changed <= 1'b1;
            end
            OP_SD_START_R:
            begin
                k_reg <= r_reg;
                r_reg <= r_reg - ONE;
            end
            OP_SD_LDV:      v_reg   <= h_rdata;
            OP_SD_LDPV:     pv_reg  <= prio_rd;
            OP_RD_LEFT:     c_reg   <= k_reg << 1;
            OP_LD_PC, OP_LD_PC_RD_R: pc_reg <= prio_rd;
            OP_RD_PRIO_HD1: hc1_reg <= h_rdata;
            OP_TAKE_RIGHT:
            begin
                c_reg  <= c_reg + ONE;
                hc_reg <= hc1_reg;
                pc_reg <= prio_rd;
            end
            OP_SD_MOVE:     k_reg <= c_reg;
            OP_EX_LDV:      out_reg.vertex_out   <= h_rdata;
            OP_EX_LDP:      out_reg.priority_out <= prio_rd;
            OP_EX_MOVE:
            begin
                k_reg <= ONE;
                v_reg <= h_rdata;
            end
            OP_FINISH:      out_reg.queue_empty <= (count_reg == '0);
            default:        k_reg <= k_reg;
        endcase
    end

    always_comb
    begin
        st.func      = func_reg;
        st.bad_upd   = (32'(vid_reg) >= 32'(MAX_VERTICES)) || (req_reg <= UNSEEN_MARK);
        st.unseen    = !valid_reg[vid_reg[PAW-1:0]];
        st.full      = (count_reg >= FULL);
        st.empty     = (count_reg == '0);
        st.count_one = (count_reg == ONE);
        st.k_is_root = (k_reg == ONE);
        st.k_is_leaf = (k_reg > (count_reg >> 1));
        st.has_right = (c_reg < count_reg);
        st.up_le     = (prio_rd <= pv_reg);
        st.raise_ok  = (prio_rd < req_reg);
        st.right_gt  = (pc_reg < prio_rd);
        st.stop      = (pv_reg >= pc_reg);
        st.r_zero    = (r_reg == '0);
        st.out_busy  = out_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("heap count beyond capacity");
    a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.error && out_reg.changed))
        else $error("error and changed both set");
    a_rise_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(op) == OP_FINISH)
        else $error("result shown without finish");
`endif

endmodule

FILE: rtl/core/indexed_max_heap_update_queue_top.sv
// Clear goes straight to done; an insert climbs one level per parent compare.
// Extract loads the root, moves the last entry there and sifts down unless count was one.
// A raise rewrites the priority, then sifts down each node from count/2 to the root.
// One request at a time; the result must be taken before the next request is accepted.
// Reset: heap count zero and all vertices unseen at once through seen bits, no sweep.
// ----------------------------------------------------------------------------
// indexed_max_heap_update_queue_top
// Indexed binary max-heap priority queue with clear, update and extract.
// ----------------------------------------------------------------------------
module indexed_max_heap_update_queue_top
    import ihq_pkg::*;
#(
    parameter int MAX_VERTICES = 128
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    dp_op_t     op;
    dp_status_t st;

    ihq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .op       (op)
    );

    ihq_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .st        (st),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
